[rtl/core/mi3_pkg.sv]
package mi3_pkg;

  // element format
  localparam int ELEM_W = 32;
  localparam int FRAC_W = 16;
  localparam int N_ELEM = 9;
  localparam int N_PROD = 2 * N_ELEM;

  // exact intermediate widths
  localparam int PROD_W = 2 * ELEM_W;            // a*b
  localparam int COF_W  = PROD_W + 1;            // a*b - c*d
  localparam int CH_W   = COF_W - ELEM_W;        // upper part of a split cofactor
  localparam int DET_W  = 3 * ELEM_W + 1;        // signed determinant
  localparam int MAG_W  = DET_W - 1;             // |det|
  localparam int NUM_W  = COF_W + 2 * FRAC_W + 1; // 2*|c|*2^(2F) + |det|
  localparam int DV_W   = MAG_W + 1;             // 2*|det|
  localparam int Q_W    = ELEM_W;                // quotient bits
  localparam int DSH_W  = DV_W + Q_W - 1;        // divisor aligned to top quotient bit
  localparam int OVF_W  = DV_W + Q_W;            // divisor aligned above quotient range

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [N_ELEM-1:0] mat_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef cof_t [N_ELEM-1:0] cofs_t;

  // cofactor k = a[PROD_A[2k]]*a[PROD_B[2k]] - a[PROD_A[2k+1]]*a[PROD_B[2k+1]]
  localparam logic [3:0] PROD_A [N_PROD] = '{
    4'd4, 4'd7, 4'd7, 4'd1, 4'd1, 4'd4, 4'd6, 4'd3, 4'd0,
    4'd6, 4'd3, 4'd0, 4'd3, 4'd6, 4'd6, 4'd0, 4'd0, 4'd3};
  localparam logic [3:0] PROD_B [N_PROD] = '{
    4'd8, 4'd5, 4'd2, 4'd8, 4'd5, 4'd2, 4'd5, 4'd8, 4'd8,
    4'd2, 4'd2, 4'd5, 4'd7, 4'd4, 4'd1, 4'd7, 4'd4, 4'd1};

  // word after the cofactor stages
  typedef struct packed {
    cofs_t c;
    elem_t [2:0] row0;
  } cof_word_t;

  // word after the determinant stages
  typedef struct packed {
    cofs_t c;
    logic signed [DET_W-1:0] det;
  } det_word_t;

  // word carried through the division steps
  typedef struct packed {
    logic [N_ELEM-1:0][NUM_W-1:0] rem;
    logic [N_ELEM-1:0][Q_W-1:0]   quo;
    logic [DSH_W-1:0]             dsh;
    logic [N_ELEM-1:0]            neg;
    logic [N_ELEM-1:0]            ovf;
    logic                         sing;
  } div_word_t;

  // full-width signed product of two elements
  function automatic logic signed [PROD_W-1:0] smul(input elem_t a, input elem_t b);
    logic signed [PROD_W-1:0] x;
    logic signed [PROD_W-1:0] y;
    x = PROD_W'(a);
    y = PROD_W'(b);
    return x * y;
  endfunction

endpackage

[rtl/core/mi3_cofactor.sv]
module mi3_cofactor (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mi3_pkg::mat_t         in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mi3_pkg::cof_word_t    out_word
);

  logic v1_r, v2_r;
  logic rdy1, rdy2;

  logic signed [mi3_pkg::PROD_W-1:0] p_r   [mi3_pkg::N_PROD];
  logic signed [mi3_pkg::PROD_W-1:0] p_nxt [mi3_pkg::N_PROD];
  mi3_pkg::elem_t [2:0] row0_1_r, row0_2_r;
  mi3_pkg::cofs_t c_r, c_nxt;

  assign rdy2      = !v2_r || out_ready;
  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // stage 1: the eighteen element products
  always_comb begin
    for (int k = 0; k < mi3_pkg::N_PROD; k++) begin
      p_nxt[k] = mi3_pkg::smul(in_word[mi3_pkg::PROD_A[k]], in_word[mi3_pkg::PROD_B[k]]);
    end
  end

  // stage 2: cofactors of the adjugate
  always_comb begin
    for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
      c_nxt[k] = mi3_pkg::COF_W'(p_r[2*k]) - mi3_pkg::COF_W'(p_r[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p_r      <= p_nxt;
      row0_1_r <= in_word[2:0];
    end
    if (rdy2) begin
      c_r      <= c_nxt;
      row0_2_r <= row0_1_r;
    end
  end

  assign out_word.c    = c_r;
  assign out_word.row0 = row0_2_r;

endmodule

[rtl/core/mi3_det.sv]
module mi3_det (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mi3_pkg::cof_word_t    in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mi3_pkg::det_word_t    out_word
);

  logic v3_r, v4_r, v5_r;
  logic rdy3, rdy4, rdy5;

  logic signed [mi3_pkg::COF_W-1:0] pl_r [3], pl_nxt [3];
  logic signed [mi3_pkg::COF_W-1:0] ph_r [3], ph_nxt [3];
  logic signed [mi3_pkg::DET_W-1:0] t_r  [3], t_nxt  [3];
  logic signed [mi3_pkg::DET_W-1:0] det_r, det_nxt;
  mi3_pkg::cofs_t c3_r, c4_r, c5_r;

  assign rdy5      = !v5_r || out_ready;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign in_ready  = rdy3;
  assign out_valid = v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= in_valid;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // stage 3: det = a00*C00 + a01*C10 + a02*C20, each cofactor split in two halves
  always_comb begin
    logic [mi3_pkg::ELEM_W-1:0]      cl;
    logic signed [mi3_pkg::CH_W-1:0] ch;
    logic signed [mi3_pkg::COF_W-1:0] ax, clx, chx;
    for (int k = 0; k < 3; k++) begin
      cl  = in_word.c[3*k][mi3_pkg::ELEM_W-1:0];
      ch  = in_word.c[3*k][mi3_pkg::COF_W-1:mi3_pkg::ELEM_W];
      ax  = mi3_pkg::COF_W'(in_word.row0[k]);
      clx = $signed(mi3_pkg::COF_W'(cl));
      chx = mi3_pkg::COF_W'(ch);
      pl_nxt[k] = ax * clx;
      ph_nxt[k] = ax * chx;
    end
  end

  // stage 4: recombine the halves
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_nxt[k] = (mi3_pkg::DET_W'(ph_r[k]) <<< mi3_pkg::ELEM_W) + mi3_pkg::DET_W'(pl_r[k]);
    end
  end

  // stage 5: sum of the three terms
  assign det_nxt = t_r[0] + t_r[1] + t_r[2];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
      c3_r <= in_word.c;
    end
    if (rdy4) begin
      t_r  <= t_nxt;
      c4_r <= c3_r;
    end
    if (rdy5) begin
      det_r <= det_nxt;
      c5_r  <= c4_r;
    end
  end

  assign out_word.c   = c5_r;
  assign out_word.det = det_r;

endmodule

[rtl/core/mi3_div_step.sv]
module mi3_div_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mi3_pkg::div_word_t    in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mi3_pkg::div_word_t    out_word
);

  logic v_r, rdy;
  mi3_pkg::div_word_t w_r, w_nxt;

  assign rdy       = !v_r || out_ready;
  assign in_ready  = rdy;
  assign out_valid = v_r;
  assign out_word  = w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  // one restoring step per lane, shared aligned divisor
  always_comb begin
    logic ge;
    w_nxt     = in_word;
    w_nxt.dsh = in_word.dsh >> 1;
    for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
      ge = mi3_pkg::DSH_W'(in_word.rem[k]) >= in_word.dsh;
      if (ge) begin
        w_nxt.rem[k] = in_word.rem[k] - in_word.dsh[mi3_pkg::NUM_W-1:0];
      end
      w_nxt.quo[k] = {in_word.quo[k][mi3_pkg::Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) w_r <= w_nxt;
  end

endmodule

[rtl/core/mi3_div.sv]
module mi3_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mi3_pkg::det_word_t    in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mi3_pkg::mat_t         out_mat,
  output logic                  out_sing
);

  logic v6_r, v7_r, vo_r;
  logic rdy6, rdy7, rdyo;

  logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::NUM_W-1:0] num6_r, num6_nxt;
  logic [mi3_pkg::DV_W-1:0]  dv6_r, dv6_nxt;
  logic [mi3_pkg::N_ELEM-1:0] neg6_r, neg6_nxt;
  logic sing6_r;
  mi3_pkg::div_word_t w7_r, w7_nxt;

  logic               sv   [mi3_pkg::Q_W+1];
  logic               srdy [mi3_pkg::Q_W+1];
  mi3_pkg::div_word_t sw   [mi3_pkg::Q_W+1];

  mi3_pkg::mat_t mat_r, mat_nxt;
  logic sing_r;

  assign rdyo              = !vo_r || out_ready;
  assign rdy7              = !v7_r || srdy[0];
  assign rdy6              = !v6_r || rdy7;
  assign in_ready          = rdy6;
  assign srdy[mi3_pkg::Q_W] = rdyo;
  assign out_valid         = vo_r;
  assign out_mat           = mat_r;
  assign out_sing          = sing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy6) v6_r <= in_valid;
      if (rdy7) v7_r <= v6_r;
      if (rdyo) vo_r <= sv[mi3_pkg::Q_W];
    end
  end

  // stage 6: signs, magnitudes, rounded numerator 2|c|*2^(2F) + |det|
  always_comb begin
    logic [mi3_pkg::COF_W-1:0] cm;
    logic [mi3_pkg::DET_W-1:0] da;
    da = in_word.det[mi3_pkg::DET_W-1] ? mi3_pkg::DET_W'(-in_word.det)
                                        : mi3_pkg::DET_W'(in_word.det);
    dv6_nxt = {da[mi3_pkg::MAG_W-1:0], 1'b0};
    for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
      cm = in_word.c[k][mi3_pkg::COF_W-1] ? mi3_pkg::COF_W'(-in_word.c[k])
                                          : mi3_pkg::COF_W'(in_word.c[k]);
      neg6_nxt[k] = in_word.c[k][mi3_pkg::COF_W-1] ^ in_word.det[mi3_pkg::DET_W-1];
      num6_nxt[k] = (mi3_pkg::NUM_W'(cm) << (2*mi3_pkg::FRAC_W+1))
                  + mi3_pkg::NUM_W'(da[mi3_pkg::MAG_W-1:0]);
    end
  end

  // stage 7: quotient overflow check and divisor alignment
  always_comb begin
    w7_nxt.rem  = num6_r;
    w7_nxt.quo  = '0;
    w7_nxt.dsh  = {dv6_r, {(mi3_pkg::Q_W-1){1'b0}}};
    w7_nxt.neg  = neg6_r;
    w7_nxt.sing = sing6_r;
    for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
      w7_nxt.ovf[k] = mi3_pkg::OVF_W'(num6_r[k]) >= {dv6_r, {mi3_pkg::Q_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      num6_r  <= num6_nxt;
      dv6_r   <= dv6_nxt;
      neg6_r  <= neg6_nxt;
      sing6_r <= (in_word.det == '0);
    end
    if (rdy7) w7_r <= w7_nxt;
  end

  assign sv[0] = v7_r;
  assign sw[0] = w7_r;

  // one quotient bit per stage, MSB first
  for (genvar i = 0; i < mi3_pkg::Q_W; i++) begin : g_step
    mi3_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sv[i]),
      .in_ready  (srdy[i]),
      .in_word   (sw[i]),
      .out_valid (sv[i+1]),
      .out_ready (srdy[i+1]),
      .out_word  (sw[i+1])
    );
  end

  // output stage: saturate, apply sign, zero when singular
  always_comb begin
    logic [mi3_pkg::Q_W-1:0] lim, mag;
    for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
      lim = sw[mi3_pkg::Q_W].neg[k] ? {1'b1, {(mi3_pkg::Q_W-1){1'b0}}}
                                   : {1'b0, {(mi3_pkg::Q_W-1){1'b1}}};
      mag = (sw[mi3_pkg::Q_W].ovf[k] || (sw[mi3_pkg::Q_W].quo[k] > lim))
          ? lim : sw[mi3_pkg::Q_W].quo[k];
      if (sw[mi3_pkg::Q_W].sing) begin
        mat_nxt[k] = '0;
      end else if (sw[mi3_pkg::Q_W].neg[k]) begin
        mat_nxt[k] = $signed(-mag);
      end else begin
        mat_nxt[k] = $signed(mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdyo) begin
      mat_r  <= mat_nxt;
      sing_r <= sw[mi3_pkg::Q_W].sing;
    end
  end

endmodule

[rtl/core/matrix_inverse_3x3.sv]
// 3x3 matrix inverse, signed Q16.16 in and out. One matrix enters per clock while
// the pipeline is not stalled by out_tready. The stages are element products and
// cofactors, the determinant (split 32x33 multiplies and sums), sign, magnitude
// and overflow setup, a restoring divider that yields one quotient bit per stage
// for all nine lanes, and an output stage for saturation.
// Every stage holds its own valid bit and fills bubbles, so the input keeps
// accepting while results wait on the output until no bubble is left. Quotients
// are rounded to nearest (ties away from zero) and saturate to the Q16.16 limits;
// a zero determinant sets out_tuser and forces all nine outputs to zero.
module matrix_inverse_3x3 (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // a00, a01, a02, a10, a11, a12, a20, a21, a22 (32b each)
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // b00, b01, b02, b10, b11, b12, b20, b21, b22 (32b each)
  output logic [0:0]   out_tuser   // singular
);

  mi3_pkg::mat_t      in_mat, out_mat;
  mi3_pkg::cof_word_t cof_word;
  mi3_pkg::det_word_t det_word;
  logic cof_valid, cof_ready, det_valid, det_ready, sing;

  assign in_mat = mi3_pkg::mat_t'(in_tdata);

  mi3_cofactor u_cof (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_word   (in_mat),
    .out_valid (cof_valid),
    .out_ready (cof_ready),
    .out_word  (cof_word)
  );

  mi3_det u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cof_valid),
    .in_ready  (cof_ready),
    .in_word   (cof_word),
    .out_valid (det_valid),
    .out_ready (det_ready),
    .out_word  (det_word)
  );

  mi3_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (det_valid),
    .in_ready  (det_ready),
    .in_word   (det_word),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_mat   (out_mat),
    .out_sing  (sing)
  );

  // output word packing
  assign out_tdata = 288'(out_mat);
  assign out_tuser = sing;

endmodule
